>>> hw/rtl/cmndf_pkg.sv
// Shared constants, types and controller codes of the pitch period finder.
package cmndf_pkg;

  localparam int IN_W            = 16;
  localparam int THR_W           = 16;
  localparam int LAG_W           = 10;
  localparam int FRAC_BITS       = 14;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1638;
  localparam int WINDOW_LEN_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_START = 9'b000000010,
    S_LAG   = 9'b000000100,
    S_ISSUE = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_MULT  = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load_en;
    logic win_start;
    logic lag_start;
    logic issue;
    logic sum;
    logic mult;
    logic res_tau;
    logic res_zero;
    logic tau_inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic early_done;
    logic n_last;
    logic pipe_empty;
    logic pass;
    logic tau_end;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/cmndf_if.sv
// Channel interfaces: sample input, lag result and threshold write.
interface cmndf_in_if;
  logic                         valid;
  logic                         ready;
  logic [cmndf_pkg::IN_W-1:0]   sample;
  logic                         last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface cmndf_out_if;
  logic                         valid;
  logic                         ready;
  logic [cmndf_pkg::LAG_W-1:0]  period_lag;
  modport source (output valid, output period_lag, input ready);
  modport sink   (input valid, input period_lag, output ready);
endinterface

interface cmndf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cmndf_pkg::THR_W-1:0]  threshold;
  modport source (output valid, output threshold, input ready);
  modport sink   (input valid, input threshold, output ready);
endinterface

>>> hw/rtl/cmndf_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
module cmndf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> hw/rtl/cmndf_ctrl.sv
// Controller state machine: sequences load, per-lag accumulation and compare.
module cmndf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  cmndf_pkg::sts_t     sts,
  output cmndf_pkg::cmd_t     cmd
);
  cmndf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmndf_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      cmndf_pkg::S_LOAD: begin
        cmd.load_en = 1'b1;
        if (sts.last_in) state_next = cmndf_pkg::S_START;
      end
      cmndf_pkg::S_START: begin
        cmd.win_start = 1'b1;
        if (sts.early_done) begin
          cmd.res_zero = 1'b1;
          state_next   = cmndf_pkg::S_DONE;
        end else begin
          state_next = cmndf_pkg::S_LAG;
        end
      end
      cmndf_pkg::S_LAG: begin
        cmd.lag_start = 1'b1;
        state_next    = cmndf_pkg::S_ISSUE;
      end
      cmndf_pkg::S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.n_last) state_next = cmndf_pkg::S_DRAIN;
      end
      cmndf_pkg::S_DRAIN: begin
        if (sts.pipe_empty) state_next = cmndf_pkg::S_SUM;
      end
      cmndf_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = cmndf_pkg::S_MULT;
      end
      cmndf_pkg::S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = cmndf_pkg::S_CMP;
      end
      cmndf_pkg::S_CMP: begin
        if (sts.pass) begin
          cmd.res_tau = 1'b1;
          state_next  = cmndf_pkg::S_DONE;
        end else if (sts.tau_end) begin
          cmd.res_zero = 1'b1;
          state_next   = cmndf_pkg::S_DONE;
        end else begin
          cmd.tau_inc = 1'b1;
          state_next  = cmndf_pkg::S_LAG;
        end
      end
      cmndf_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = cmndf_pkg::S_LOAD;
        end
      end
      default: state_next = cmndf_pkg::S_LOAD;
    endcase
  end
endmodule

>>> hw/rtl/cmndf_dp.sv
// Datapath: sample store, squared-difference pipe, running sum and compare.
module cmndf_dp #(
  parameter int WINDOW_LEN  = cmndf_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = cmndf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmndf_pkg::cmd_t             cmd,
  output cmndf_pkg::sts_t             sts,
  input  logic                        in_valid,
  input  logic [cmndf_pkg::IN_W-1:0]  in_sample,
  input  logic                        in_last,
  input  logic                        cfg_we,
  input  logic [cmndf_pkg::THR_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cmndf_pkg::LAG_W-1:0] out_lag
);
  localparam int AW   = $clog2(WINDOW_LEN);
  localparam int CW   = $clog2(WINDOW_LEN + 1);
  localparam int SB   = SAMPLE_BITS;
  localparam int SQW  = 2 * SB;
  localparam int DW   = SQW + AW;
  localparam int SW   = DW + AW;
  localparam int LW   = DW + CW + cmndf_pkg::FRAC_BITS;
  localparam int RW   = SW + cmndf_pkg::THR_W;
  localparam int CMPW = (LW > RW) ? LW : RW;

  logic [cmndf_pkg::THR_W-1:0] threshold;
  logic [CW-1:0]    fill, len, tau, n;
  logic [SB-1:0]    rd_a, rd_b;
  logic             v1, v2;
  logic [SQW-1:0]   sq;
  logic [DW-1:0]    d;
  logic [SW-1:0]    s;
  logic [DW+CW-1:0] lhs;
  logic [RW-1:0]    rhs;
  logic             beat, wr_en;
  logic signed [SB:0] delta;
  logic [SB-1:0]    mag;
  logic [CW:0]      n_tau;

  assign beat  = in_valid && cmd.load_en;
  assign wr_en = beat && (fill < CW'(WINDOW_LEN));
  assign n_tau = {1'b0, n} + {1'b0, tau};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= cmndf_pkg::THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (beat) begin
      fill <= in_last ? '0 : (wr_en ? fill + 1'b1 : fill);
    end
  end

  always_ff @(posedge clk) begin
    if (beat && in_last) begin
      len <= wr_en ? fill + 1'b1 : fill;
    end
  end

  cmndf_ram #(.WIDTH(SB), .DEPTH(WINDOW_LEN)) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (fill[AW-1:0]),
    .wdata   (in_sample[SB-1:0]),
    .raddr_a (n[AW-1:0]),
    .raddr_b (n_tau[AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // lag and sample counters
  always_ff @(posedge clk) begin
    if (cmd.win_start) tau <= CW'(1);
    else if (cmd.tau_inc) tau <= tau + 1'b1;
    if (cmd.lag_start) n <= '0;
    else if (cmd.issue) n <= n + 1'b1;
  end

  // pipe valids: read data, then square
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  assign delta = $signed({rd_a[SB-1], rd_a}) - $signed({rd_b[SB-1], rd_b});
  assign mag   = delta[SB] ? SB'(-delta) : delta[SB-1:0];

  always_ff @(posedge clk) begin
    sq <= SQW'(mag * mag);
    if (cmd.lag_start) d <= '0;
    else if (v2) d <= d + DW'(sq);
    if (cmd.win_start) s <= '0;
    else if (cmd.sum) s <= s + SW'(d);
    if (cmd.mult) begin
      lhs <= (DW+CW)'(d * tau);
      rhs <= RW'(s * threshold);
    end
  end

  // result register toward the output channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  logic [cmndf_pkg::LAG_W-1:0] res;
  always_ff @(posedge clk) begin
    if (cmd.res_tau) res <= cmndf_pkg::LAG_W'(tau);
    else if (cmd.res_zero) res <= '0;
    if (cmd.emit) out_lag <= res;
  end

  always_comb begin
    sts.last_in    = beat && in_last;
    sts.early_done = (threshold[cmndf_pkg::THR_W-1:cmndf_pkg::FRAC_BITS] != '0)
                     || (len <= CW'(1));
    sts.n_last     = (n_tau + 1'b1) == {1'b0, len};
    sts.pipe_empty = !v1 && !v2;
    sts.pass       = (s != '0) &&
                     (CMPW'({lhs, {cmndf_pkg::FRAC_BITS{1'b0}}}) <= CMPW'(rhs));
    sts.tau_end    = ({1'b0, tau} + 1'b1) >= {1'b0, len};
    sts.out_busy   = out_valid;
  end
endmodule

>>> hw/rtl/cmndf_pitch_period_finder_core.sv
// Top level of the pitch period finder: controller, datapath and channels.
//
// Use: stream one analysis window of signed samples on in_ch, one sample per
// beat, with last_sample set on the final beat. Up to WINDOW_LEN samples are
// stored; later ones in the same window are dropped, though a last mark on
// them still ends the window. After the last beat the block searches lags
// tau = 1 .. L-1 for the first one whose cumulative mean normalized
// difference is at or below threshold, and puts one beat on out_ch: that
// lag, or 0 if none passes or threshold >= 1.0.
// Timing: one sample store read pair per cycle sets the pace. Lag tau issues
// (L - tau) read pairs, then drains the pipe, sums, multiplies and compares.
// in_ch is not ready while a window is being searched.
// A result waiting on a stalled out_ch does not block loading of the next
// window; only the next result waits for it to be taken.
// cfg carries threshold writes, always ready; write only while idle.
// Reset (rst, synchronous): empty window, no result pending, threshold 1638.
module cmndf_pitch_period_finder_core #(
  parameter int WINDOW_LEN  = cmndf_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = cmndf_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cmndf_in_if.sink     in_ch,
  cmndf_out_if.source  out_ch,
  cmndf_cfg_if.sink    cfg
);
  cmndf_pkg::cmd_t cmd;
  cmndf_pkg::sts_t sts;

  // samples are taken only while the controller is loading
  assign in_ch.ready = cmd.load_en;
  assign cfg.ready   = 1'b1;

  cmndf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  cmndf_dp #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.sample),
    .in_last   (in_ch.last_sample),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.threshold),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_lag   (out_ch.period_lag)
  );

  // a result beat appears only after the controller hands one over
  a_emit_before_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.emit))
    else $error("result valid without emit");

  // no sample is taken while a lag search is issuing reads
  a_no_load_in_search: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !in_ch.ready)
    else $error("input ready during lag search");

  // emit never overwrites a pending result
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_ch.valid)
    else $error("emit while result pending");
endmodule
